### rtl/gyi_pkg.sv
// gyi_pkg: widths, codes, types and constants shared by the yaw integrator files
`timescale 1ns / 1ps

package gyi_pkg;

    localparam int RATE_WIDTH     = 20;
    localparam int COUNT_WIDTH    = 16;
    localparam int TARGET_WIDTH   = COUNT_WIDTH;
    localparam int BIAS_WIDTH     = 20;
    localparam int TIME_WIDTH     = 32;
    localparam int SET_WIDTH      = 32;
    localparam int YAW_WIDTH      = 48;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;

    localparam int SUM_WIDTH   = RATE_WIDTH + COUNT_WIDTH;
    localparam int BIASV_WIDTH = (RATE_WIDTH > BIAS_WIDTH) ? RATE_WIDTH : BIAS_WIDTH;
    localparam int DIFF_WIDTH  = BIASV_WIDTH + 1;
    localparam int MAG_WIDTH   = (DIFF_WIDTH > SET_WIDTH) ? DIFF_WIDTH : SET_WIDTH;
    localparam int PROD_WIDTH  = MAG_WIDTH + TIME_WIDTH;
    localparam int EXT_WIDTH   = YAW_WIDTH + 2;
    localparam int DCNT_WIDTH  = $clog2(SUM_WIDTH);

    // yaw set command is in 1/256 degree, yaw is kept in 1/256 millidegree
    localparam int YAW_SCALE = 1000;

    localparam logic signed [YAW_WIDTH-1:0] YAW_MAX = {1'b0, {(YAW_WIDTH-1){1'b1}}};
    localparam logic signed [YAW_WIDTH-1:0] YAW_MIN = {1'b1, {(YAW_WIDTH-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TARGET     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_STEP   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_BIAS  = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BIAS_FIXED = 2'd3;

    // register reset values
    localparam logic [TARGET_WIDTH-1:0]      RST_TARGET     = 16'd100;
    localparam logic [TIME_WIDTH-1:0]        RST_MAX_STEP   = 32'd100;
    localparam logic signed [BIAS_WIDTH-1:0] RST_INIT_BIAS  = '0;
    localparam logic                         RST_BIAS_FIXED = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic neg;
    } t_mac_req;

endpackage

### rtl/gyi_div.sv
// gyi_div: restoring divider, one quotient bit per cycle, for the bias average
`timescale 1ns / 1ps

module gyi_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [gyi_pkg::SUM_WIDTH-1:0] i_dividend,
    input  logic [gyi_pkg::COUNT_WIDTH-1:0]      i_divisor,
    output logic                                 o_done,
    output logic signed [gyi_pkg::SUM_WIDTH-1:0] o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [gyi_pkg::DCNT_WIDTH-1:0]     r_cnt;
    logic [gyi_pkg::COUNT_WIDTH-1:0]    r_rem;
    logic [gyi_pkg::SUM_WIDTH-1:0]      r_quo;
    logic [gyi_pkg::COUNT_WIDTH-1:0]    r_den;
    logic                               r_neg;

    logic [gyi_pkg::COUNT_WIDTH:0]      w_trial;
    logic                               w_ge;
    logic [gyi_pkg::COUNT_WIDTH:0]      w_diff;
    logic [gyi_pkg::SUM_WIDTH-1:0]      w_abs;

    assign w_abs   = i_dividend[gyi_pkg::SUM_WIDTH-1] ? -i_dividend : i_dividend;
    assign w_trial = {r_rem, r_quo[gyi_pkg::SUM_WIDTH-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= gyi_pkg::DCNT_WIDTH'(gyi_pkg::SUM_WIDTH - 1);
                r_rem  <= '0;
                r_quo  <= w_abs;
                r_den  <= i_divisor;
                r_neg  <= i_dividend[gyi_pkg::SUM_WIDTH-1];
            end else if (r_busy) begin
                // shift in the next dividend bit, quotient bits fill from the right
                r_rem <= w_ge ? w_diff[gyi_pkg::COUNT_WIDTH-1:0]
                              : w_trial[gyi_pkg::COUNT_WIDTH-1:0];
                r_quo <= {r_quo[gyi_pkg::SUM_WIDTH-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign o_done     = r_done;

endmodule

### rtl/gyi_mac.sv
// gyi_mac: registered magnitude multiply followed by a capped, saturating yaw add
`timescale 1ns / 1ps

module gyi_mac (
    input  logic                                 i_clk,
    input  gyi_pkg::t_mac_req                    i_req,
    input  logic [gyi_pkg::MAG_WIDTH-1:0]        i_mag,
    input  logic [gyi_pkg::TIME_WIDTH-1:0]       i_mult,
    input  logic signed [gyi_pkg::YAW_WIDTH-1:0] i_base,
    output logic signed [gyi_pkg::YAW_WIDTH-1:0] o_yaw
);

    localparam logic [gyi_pkg::PROD_WIDTH-1:0] PROD_CAP =
        gyi_pkg::PROD_WIDTH'(1) << gyi_pkg::YAW_WIDTH;

    logic [gyi_pkg::PROD_WIDTH-1:0]        r_prod;
    logic                                  r_neg;
    logic signed [gyi_pkg::YAW_WIDTH-1:0]  r_base;

    logic [gyi_pkg::YAW_WIDTH:0]           w_capped;
    logic signed [gyi_pkg::EXT_WIDTH-1:0]  w_term;
    logic signed [gyi_pkg::EXT_WIDTH-1:0]  w_sum;

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_prod <= gyi_pkg::PROD_WIDTH'(i_mag) * gyi_pkg::PROD_WIDTH'(i_mult);
            r_neg  <= i_req.neg;
            r_base <= i_base;
        end
    end

    always_comb begin
        // products past the full yaw range are clamped before the add
        w_capped = (r_prod > PROD_CAP) ? PROD_CAP[gyi_pkg::YAW_WIDTH:0]
                                       : r_prod[gyi_pkg::YAW_WIDTH:0];
        w_term   = $signed(gyi_pkg::EXT_WIDTH'(w_capped));
        w_sum    = gyi_pkg::EXT_WIDTH'(r_base) + (r_neg ? -w_term : w_term);
        if (w_sum > gyi_pkg::EXT_WIDTH'(gyi_pkg::YAW_MAX)) begin
            o_yaw = gyi_pkg::YAW_MAX;
        end else if (w_sum < gyi_pkg::EXT_WIDTH'(gyi_pkg::YAW_MIN)) begin
            o_yaw = gyi_pkg::YAW_MIN;
        end else begin
            o_yaw = w_sum[gyi_pkg::YAW_WIDTH-1:0];
        end
    end

endmodule

### rtl/gyro_yaw_integrator.sv
// gyro_yaw_integrator: bias-calibrated yaw integration of z-axis rate samples
// steps: an accepted beat runs EXEC then OUT for a step with no yaw update, EXEC, ACC
//   and OUT for an integration step or a yaw set, and EXEC, DIV and OUT when calibration
//   completes; the 36-step divider lengthens calibration, the multiply and add the rest
// one item at a time: the next beat is taken back in IDLE, held off by output stalls
// reset (synchronous, active low) and any register write restart the integrator state
`timescale 1ns / 1ps

module gyro_yaw_integrator (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,

    input  logic                                      i_cfg_we,
    input  logic [gyi_pkg::CFG_IDX_WIDTH-1:0]         i_cfg_index,
    input  logic [gyi_pkg::CFG_DATA_WIDTH-1:0]        i_cfg_data,

    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic                                      i_kind,
    input  logic signed [gyi_pkg::RATE_WIDTH-1:0]     i_rate_value,
    input  logic [gyi_pkg::TIME_WIDTH-1:0]            i_sample_time,
    input  logic signed [gyi_pkg::SET_WIDTH-1:0]      i_yaw_set_value,

    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic                                      o_accepted,
    output logic                                      o_is_calibrated,
    output logic                                      o_sample_valid,
    output logic signed [gyi_pkg::YAW_WIDTH-1:0]      o_yaw_angle,
    output logic [gyi_pkg::TIME_WIDTH-1:0]            o_last_time
);

    gyi_pkg::t_state r_state;
    gyi_pkg::t_state n_state;

    // configuration
    logic [gyi_pkg::TARGET_WIDTH-1:0]       r_cfg_target;
    logic [gyi_pkg::TIME_WIDTH-1:0]         r_cfg_max;
    logic signed [gyi_pkg::BIAS_WIDTH-1:0]  r_cfg_bias;
    logic                                   r_cfg_fixed;
    logic [gyi_pkg::TARGET_WIDTH-1:0]       n_cfg_target;
    logic [gyi_pkg::TIME_WIDTH-1:0]         n_cfg_max;
    logic signed [gyi_pkg::BIAS_WIDTH-1:0]  n_cfg_bias;
    logic                                   n_cfg_fixed;

    // integrator state
    logic                                   r_cal;
    logic                                   r_held;
    logic [gyi_pkg::TIME_WIDTH-1:0]         r_prev;
    logic signed [gyi_pkg::SUM_WIDTH-1:0]   r_sum;
    logic [gyi_pkg::COUNT_WIDTH-1:0]        r_seen;
    logic signed [gyi_pkg::BIASV_WIDTH-1:0] r_bias;
    logic signed [gyi_pkg::YAW_WIDTH-1:0]   r_yaw;

    // current item
    logic                                   r_kind;
    logic signed [gyi_pkg::RATE_WIDTH-1:0]  r_rate;
    logic [gyi_pkg::TIME_WIDTH-1:0]         r_time;
    logic signed [gyi_pkg::SET_WIDTH-1:0]   r_set;
    logic                                   r_acc;

    // output register
    logic                                   r_out_valid;
    logic                                   r_out_acc;
    logic                                   r_out_cal;
    logic                                   r_out_sv;
    logic signed [gyi_pkg::YAW_WIDTH-1:0]   r_out_yaw;
    logic [gyi_pkg::TIME_WIDTH-1:0]         r_out_time;

    logic                                   w_in_beat;
    logic                                   w_out_beat;
    logic                                   w_out_load;
    logic signed [gyi_pkg::SUM_WIDTH-1:0]   w_cal_sum;
    logic [gyi_pkg::COUNT_WIDTH-1:0]        w_seen_inc;
    logic                                   w_cal_done;
    logic [gyi_pkg::TIME_WIDTH-1:0]         w_gap;
    logic                                   w_gap_ok;
    logic signed [gyi_pkg::DIFF_WIDTH-1:0]  w_diff;
    logic [gyi_pkg::DIFF_WIDTH-1:0]         w_diff_mag;
    logic [gyi_pkg::SET_WIDTH-1:0]          w_set_mag;
    logic                                   w_valid;

    logic                                   w_div_start;
    logic                                   w_div_done;
    logic signed [gyi_pkg::SUM_WIDTH-1:0]   w_div_quo;

    gyi_pkg::t_mac_req                      w_mac_req;
    logic [gyi_pkg::MAG_WIDTH-1:0]          w_mac_mag;
    logic [gyi_pkg::TIME_WIDTH-1:0]         w_mac_mult;
    logic signed [gyi_pkg::YAW_WIDTH-1:0]   w_mac_base;
    logic signed [gyi_pkg::YAW_WIDTH-1:0]   w_mac_yaw;

    assign o_in_stall = (r_state != gyi_pkg::ST_IDLE);
    assign w_in_beat  = i_in_valid && !o_in_stall;
    assign w_out_beat = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == gyi_pkg::ST_OUT) && (!r_out_valid || !i_out_stall);

    // item arithmetic
    assign w_cal_sum  = r_sum + gyi_pkg::SUM_WIDTH'(r_rate);
    assign w_seen_inc = r_seen + 1'b1;
    assign w_cal_done = (w_seen_inc >= r_cfg_target) && (w_seen_inc != '0);
    assign w_gap      = r_time - r_prev;
    assign w_gap_ok   = (w_gap != '0) && (w_gap <= r_cfg_max);
    assign w_diff     = gyi_pkg::DIFF_WIDTH'(r_rate) - gyi_pkg::DIFF_WIDTH'(r_bias);
    assign w_diff_mag = w_diff[gyi_pkg::DIFF_WIDTH-1] ? -w_diff : w_diff;
    assign w_set_mag  = r_set[gyi_pkg::SET_WIDTH-1] ? -r_set : r_set;
    assign w_valid    = r_cal && r_held;

    // a yaw set is the same multiply with a zero base and a fixed multiplier
    assign w_mac_mag  = r_kind ? gyi_pkg::MAG_WIDTH'(w_set_mag)
                               : gyi_pkg::MAG_WIDTH'(w_diff_mag);
    assign w_mac_mult = r_kind ? gyi_pkg::TIME_WIDTH'(gyi_pkg::YAW_SCALE) : w_gap;
    assign w_mac_base = r_kind ? '0 : r_yaw;

    // configuration next values, restart takes these
    always_comb begin
        n_cfg_target = r_cfg_target;
        n_cfg_max    = r_cfg_max;
        n_cfg_bias   = r_cfg_bias;
        n_cfg_fixed  = r_cfg_fixed;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                gyi_pkg::CFG_TARGET:     n_cfg_target = i_cfg_data[gyi_pkg::TARGET_WIDTH-1:0];
                gyi_pkg::CFG_MAX_STEP:   n_cfg_max    = i_cfg_data[gyi_pkg::TIME_WIDTH-1:0];
                gyi_pkg::CFG_INIT_BIAS:  n_cfg_bias   = i_cfg_data[gyi_pkg::BIAS_WIDTH-1:0];
                gyi_pkg::CFG_BIAS_FIXED: n_cfg_fixed  = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gyi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_div_start   = 1'b0;
        w_mac_req     = '0;
        w_mac_req.neg = r_kind ? r_set[gyi_pkg::SET_WIDTH-1] : w_diff[gyi_pkg::DIFF_WIDTH-1];
        unique case (r_state)
            gyi_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    n_state = gyi_pkg::ST_EXEC;
                end
            end
            gyi_pkg::ST_EXEC: begin
                if (r_kind || (r_cal && r_held && w_gap_ok)) begin
                    w_mac_req.load = 1'b1;
                    n_state        = gyi_pkg::ST_ACC;
                end else if (!r_cal && w_cal_done) begin
                    w_div_start = 1'b1;
                    n_state     = gyi_pkg::ST_DIV;
                end else begin
                    n_state = gyi_pkg::ST_OUT;
                end
            end
            gyi_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = gyi_pkg::ST_OUT;
                end
            end
            gyi_pkg::ST_ACC: begin
                n_state = gyi_pkg::ST_OUT;
            end
            gyi_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = gyi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gyi_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) begin
                r_cfg_target <= gyi_pkg::RST_TARGET;
                r_cfg_max    <= gyi_pkg::RST_MAX_STEP;
                r_cfg_bias   <= gyi_pkg::RST_INIT_BIAS;
                r_cfg_fixed  <= gyi_pkg::RST_BIAS_FIXED;
                r_cal        <= gyi_pkg::RST_BIAS_FIXED || (gyi_pkg::RST_TARGET == '0);
                r_bias       <= gyi_pkg::BIASV_WIDTH'(gyi_pkg::RST_INIT_BIAS);
            end else begin
                r_cfg_target <= n_cfg_target;
                r_cfg_max    <= n_cfg_max;
                r_cfg_bias   <= n_cfg_bias;
                r_cfg_fixed  <= n_cfg_fixed;
                r_cal        <= n_cfg_fixed || (n_cfg_target == '0);
                r_bias       <= gyi_pkg::BIASV_WIDTH'(n_cfg_bias);
            end
            r_held <= 1'b0;
            r_prev <= '0;
            r_sum  <= '0;
            r_seen <= '0;
            r_yaw  <= '0;
            r_acc  <= 1'b0;
        end else begin
            unique case (r_state)
                gyi_pkg::ST_EXEC: begin
                    if (r_kind) begin
                        r_acc <= 1'b0;
                    end else if (!r_cal) begin
                        r_sum  <= w_cal_sum;
                        r_seen <= w_seen_inc;
                        r_prev <= r_time;
                        r_held <= 1'b1;
                        r_acc  <= 1'b0;
                    end else if (!r_held) begin
                        r_prev <= r_time;
                        r_held <= 1'b1;
                        r_acc  <= 1'b1;
                    end else begin
                        // a rejected gap still moves the time base
                        r_prev <= r_time;
                        r_acc  <= w_gap_ok;
                    end
                end
                gyi_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        r_bias <= w_div_quo[gyi_pkg::BIASV_WIDTH-1:0];
                        r_cal  <= 1'b1;
                        r_yaw  <= '0;
                        r_acc  <= 1'b1;
                    end
                end
                gyi_pkg::ST_ACC: begin
                    r_yaw <= w_mac_yaw;
                end
                gyi_pkg::ST_IDLE, gyi_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_kind <= i_kind;
            r_rate <= i_rate_value;
            r_time <= i_sample_time;
            r_set  <= i_yaw_set_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_acc  <= r_acc;
            r_out_cal  <= r_cal;
            r_out_sv   <= w_valid;
            r_out_yaw  <= w_valid ? r_yaw : '0;
            r_out_time <= w_valid ? r_prev : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_acc;
    assign o_is_calibrated = r_out_cal;
    assign o_sample_valid  = r_out_sv;
    assign o_yaw_angle     = r_out_yaw;
    assign o_last_time     = r_out_time;

    gyi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cal_sum),
        .i_divisor  (w_seen_inc),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    gyi_mac u_mac (
        .i_clk  (i_clk),
        .i_req  (w_mac_req),
        .i_mag  (w_mac_mag),
        .i_mult (w_mac_mult),
        .i_base (w_mac_base),
        .o_yaw  (w_mac_yaw)
    );

    // the sample count stays below the target until the bias divide starts
    a_seen_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cal |-> ((r_state == gyi_pkg::ST_DIV) || (r_seen < r_cfg_target)))
        else $error("calibration count reached target while uncalibrated");

    // the divider only reports completion while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == gyi_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    // a valid sample implies completed calibration
    a_valid_needs_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_valid) |-> o_is_calibrated)
        else $error("sample valid reported without calibration");

    // without a valid sample the yaw and time fields read zero
    a_invalid_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sample_valid) |-> ((o_yaw_angle == '0) && (o_last_time == '0)))
        else $error("yaw or time nonzero on an invalid sample");

endmodule

### sim/tb_gyro_yaw_integrator.sv
// tb_gyro_yaw_integrator: self-checking testbench for the bias-calibrated yaw integrator
`timescale 1ns / 1ps

module tb_gyro_yaw_integrator;

    localparam logic KIND_RATE    = 1'b0;
    localparam logic KIND_YAW_SET = 1'b1;
    localparam longint PROD_CAP   = longint'(1) << gyi_pkg::YAW_WIDTH;

    typedef struct {
        logic                                 accepted;
        logic                                 is_calibrated;
        logic                                 sample_valid;
        logic signed [gyi_pkg::YAW_WIDTH-1:0] yaw_angle;
        logic [gyi_pkg::TIME_WIDTH-1:0]       last_time;
    } t_yaw_result;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_cfg_we;
    logic [gyi_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index;
    logic [gyi_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data;
    logic                                   i_in_valid;
    logic                                   o_in_stall;
    logic                                   i_kind;
    logic signed [gyi_pkg::RATE_WIDTH-1:0]  i_rate_value;
    logic [gyi_pkg::TIME_WIDTH-1:0]         i_sample_time;
    logic signed [gyi_pkg::SET_WIDTH-1:0]   i_yaw_set_value;
    logic                                   o_out_valid;
    logic                                   i_out_stall;
    logic                                   o_accepted;
    logic                                   o_is_calibrated;
    logic                                   o_sample_valid;
    logic signed [gyi_pkg::YAW_WIDTH-1:0]   o_yaw_angle;
    logic [gyi_pkg::TIME_WIDTH-1:0]         o_last_time;

    gyro_yaw_integrator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_rate_value    (i_rate_value),
        .i_sample_time   (i_sample_time),
        .i_yaw_set_value (i_yaw_set_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_is_calibrated (o_is_calibrated),
        .o_sample_valid  (o_sample_valid),
        .o_yaw_angle     (o_yaw_angle),
        .o_last_time     (o_last_time)
    );

    // register copies
    logic [gyi_pkg::TARGET_WIDTH-1:0]      reg_target;
    logic [gyi_pkg::TIME_WIDTH-1:0]        reg_max_step;
    logic signed [gyi_pkg::BIAS_WIDTH-1:0] reg_init_bias;
    logic                                  reg_bias_fixed;

    // integrator state
    logic                                  cal_done;
    logic                                  stamp_held;
    logic [gyi_pkg::TIME_WIDTH-1:0]        last_stamp;
    longint                                rate_sum;
    logic [gyi_pkg::COUNT_WIDTH-1:0]       rate_count;
    longint                                bias_est;
    longint                                yaw_acc;

    t_yaw_result pending_results[$];
    int          error_count;
    int          send_idle_pct;
    int          out_stall_pct;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic void restart_state();
        cal_done   = reg_bias_fixed || (reg_target == 0);
        stamp_held = 1'b0;
        last_stamp = '0;
        rate_sum   = 0;
        rate_count = '0;
        bias_est   = longint'(reg_init_bias);
        yaw_acc    = 0;
    endfunction

    function automatic t_yaw_result predict_yaw_result(
        input logic                                  kind,
        input logic signed [gyi_pkg::RATE_WIDTH-1:0] rate,
        input logic [gyi_pkg::TIME_WIDTH-1:0]        stamp,
        input logic signed [gyi_pkg::SET_WIDTH-1:0]  yaw_set
    );
        t_yaw_result                    res;
        logic [gyi_pkg::TIME_WIDTH-1:0] gap;
        longint                         diff;
        longint                         mag;
        longint                         prod;
        longint                         sum;
        res.accepted = 1'b0;
        if (kind == KIND_YAW_SET) begin
            yaw_acc = longint'(yaw_set) * gyi_pkg::YAW_SCALE;
        end else if (!cal_done) begin
            rate_sum   += longint'(rate);
            rate_count += 1'b1;
            last_stamp  = stamp;
            stamp_held  = 1'b1;
            if (rate_count >= reg_target && rate_count != 0) begin
                // truncates toward zero
                bias_est = rate_sum / longint'(rate_count);
                cal_done = 1'b1;
                yaw_acc  = 0;
            end
            res.accepted = cal_done;
        end else if (!stamp_held) begin
            last_stamp   = stamp;
            stamp_held   = 1'b1;
            res.accepted = 1'b1;
        end else begin
            gap        = stamp - last_stamp;
            last_stamp = stamp;
            if (gap != 0 && gap <= reg_max_step) begin
                diff = longint'(rate) - bias_est;
                mag  = (diff < 0) ? -diff : diff;
                if (mag != 0 && longint'(gap) > PROD_CAP / mag)
                    prod = PROD_CAP;
                else
                    prod = mag * longint'(gap);
                sum = (diff < 0) ? yaw_acc - prod : yaw_acc + prod;
                if (sum > longint'(gyi_pkg::YAW_MAX))
                    yaw_acc = longint'(gyi_pkg::YAW_MAX);
                else if (sum < longint'(gyi_pkg::YAW_MIN))
                    yaw_acc = longint'(gyi_pkg::YAW_MIN);
                else
                    yaw_acc = sum;
                res.accepted = 1'b1;
            end
        end
        res.is_calibrated = cal_done;
        res.sample_valid  = cal_done && stamp_held;
        res.yaw_angle     = res.sample_valid ? yaw_acc[gyi_pkg::YAW_WIDTH-1:0] : '0;
        res.last_time     = res.sample_valid ? last_stamp : '0;
        return res;
    endfunction

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
    endtask

    task automatic send_item(
        input logic                                  kind,
        input logic signed [gyi_pkg::RATE_WIDTH-1:0] rate,
        input logic [gyi_pkg::TIME_WIDTH-1:0]        stamp,
        input logic signed [gyi_pkg::SET_WIDTH-1:0]  yaw_set
    );
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_rate_value    <= rate;
        i_sample_time   <= stamp;
        i_yaw_set_value <= yaw_set;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_yaw_result(kind, rate, stamp, yaw_set));
    endtask

    // drains the block before the write, any write restarts the integrator state
    task automatic write_reg(input logic [gyi_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [gyi_pkg::CFG_DATA_WIDTH-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gyi_pkg::CFG_TARGET:     reg_target     = data[gyi_pkg::TARGET_WIDTH-1:0];
            gyi_pkg::CFG_MAX_STEP:   reg_max_step   = data[gyi_pkg::TIME_WIDTH-1:0];
            gyi_pkg::CFG_INIT_BIAS:  reg_init_bias  = data[gyi_pkg::BIAS_WIDTH-1:0];
            gyi_pkg::CFG_BIAS_FIXED: reg_bias_fixed = data[0];
            default: ;
        endcase
        restart_state();
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_yaw_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, got yaw %0h",
                         $time, o_yaw_angle);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", 64'(want.accepted), 64'(o_accepted));
                check_field("is_calibrated", 64'(want.is_calibrated), 64'(o_is_calibrated));
                check_field("sample_valid", 64'(want.sample_valid), 64'(o_sample_valid));
                check_field("yaw_angle", 64'(want.yaw_angle), 64'(o_yaw_angle));
                check_field("last_time", 64'(want.last_time), 64'(o_last_time));
            end
        end
    end

    task automatic test_calibration();
        // default target of 100: samples are only summed, yaw set lands mid calibration
        send_item(KIND_YAW_SET, '0, 32'd0, 32'sh7FFF_FFFF);
        send_item(KIND_RATE, 20'sh7FFFF, 32'd5, '0);
        send_item(KIND_RATE, 20'sh80000, 32'd6, '0);
        // completion overrides the initial bias and clears the set yaw
        write_reg(gyi_pkg::CFG_TARGET, 32'd3);
        write_reg(gyi_pkg::CFG_INIT_BIAS, 32'hFFFF_FFFB);
        send_item(KIND_RATE, 20'sh7FFFF, 32'd100, '0);
        send_item(KIND_YAW_SET, '0, 32'd0, 32'sh0123_4567);
        send_item(KIND_RATE, 20'sh80000, 32'd110, '0);
        send_item(KIND_RATE, 20'sd7, 32'd120, '0);
        // negative average truncates toward zero
        write_reg(gyi_pkg::CFG_TARGET, 32'd2);
        write_reg(gyi_pkg::CFG_INIT_BIAS, 32'd0);
        send_item(KIND_RATE, -20'sd3, 32'd7, '0);
        send_item(KIND_RATE, 20'sd0, 32'd8, '0);
    endtask

    task automatic test_step_gaps();
        write_reg(gyi_pkg::CFG_TARGET, 32'd1);
        write_reg(gyi_pkg::CFG_MAX_STEP, 32'd100);
        send_item(KIND_RATE, 20'sd200, 32'd1000, '0);
        send_item(KIND_RATE, 20'sd1000, 32'd1000, '0);
        send_item(KIND_RATE, 20'sd1000, 32'd1101, '0);
        send_item(KIND_RATE, 20'sh80000, 32'd1201, '0);
        send_item(KIND_RATE, 20'sh7FFFF, 32'd1202, '0);
        send_item(KIND_YAW_SET, '0, 32'd1202, 32'sh8000_0000);
        // timestamp wrap: huge gap rejected, then a short gap across zero
        send_item(KIND_RATE, -20'sd300, 32'hFFFF_FFF0, '0);
        send_item(KIND_RATE, -20'sd300, 32'h0000_0010, '0);
    endtask

    task automatic test_yaw_saturation();
        write_reg(gyi_pkg::CFG_MAX_STEP, 32'hFFFF_FFFF);
        write_reg(gyi_pkg::CFG_INIT_BIAS, 32'hFFF8_0000);
        write_reg(gyi_pkg::CFG_BIAS_FIXED, 32'd1);
        send_item(KIND_RATE, 20'sd0, 32'd0, '0);
        send_item(KIND_RATE, 20'sh7FFFF, 32'hFFFF_FFFF, '0);
        send_item(KIND_RATE, 20'sh80000, 32'd0, '0);
        write_reg(gyi_pkg::CFG_INIT_BIAS, 32'h0007_FFFF);
        send_item(KIND_RATE, 20'sd0, 32'd5, '0);
        send_item(KIND_RATE, 20'sh80000, 32'h8000_0005, '0);
    endtask

    task automatic test_register_extremes();
        // zero target is calibrated at once, zero max step rejects every gap
        write_reg(gyi_pkg::CFG_BIAS_FIXED, 32'd0);
        write_reg(gyi_pkg::CFG_TARGET, 32'd0);
        write_reg(gyi_pkg::CFG_MAX_STEP, 32'd0);
        send_item(KIND_RATE, 20'sd40, 32'd1, '0);
        send_item(KIND_RATE, 20'sd40, 32'd2, '0);
        write_reg(gyi_pkg::CFG_TARGET, 32'd65535);
        send_item(KIND_RATE, 20'sd40, 32'd3, '0);
    endtask

    task automatic test_random_traffic();
        int                                    pct;
        int                                    small_rate;
        logic [gyi_pkg::TIME_WIDTH-1:0]        stamp_now;
        logic [gyi_pkg::TIME_WIDTH-1:0]        gap;
        logic [gyi_pkg::TIME_WIDTH-1:0]        gap_hi;
        logic [gyi_pkg::BIAS_WIDTH-1:0]        bias_bits;
        logic signed [gyi_pkg::RATE_WIDTH-1:0] rate;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(60, 0);
                2: set_idling(0, 60);
                default: set_idling(23, 23);
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                pct = $urandom_range(99);
                write_reg(gyi_pkg::CFG_TARGET,
                          (pct < 10) ? 32'd0 : 32'($urandom_range(1, 8)));
                pct = $urandom_range(99);
                write_reg(gyi_pkg::CFG_MAX_STEP, (pct < 15) ? 32'hFFFF_FFFF :
                          (pct < 20) ? 32'd0 : 32'($urandom_range(1, 300)));
                bias_bits = gyi_pkg::BIAS_WIDTH'($urandom);
                write_reg(gyi_pkg::CFG_INIT_BIAS,
                          {{(gyi_pkg::CFG_DATA_WIDTH-gyi_pkg::BIAS_WIDTH)
                            {bias_bits[gyi_pkg::BIAS_WIDTH-1]}}, bias_bits});
                write_reg(gyi_pkg::CFG_BIAS_FIXED, 32'($urandom_range(99) < 30));
                stamp_now = $urandom;
                for (int n = 0; n < 25; n++) begin
                    if ($urandom_range(1)) begin
                        rate = gyi_pkg::RATE_WIDTH'($urandom);
                    end else begin
                        small_rate = int'($urandom_range(1023)) - 512;
                        rate = gyi_pkg::RATE_WIDTH'(small_rate);
                    end
                    if ($urandom_range(99) < 5) begin
                        send_item(KIND_YAW_SET, rate, $urandom, $urandom);
                    end else begin
                        pct    = $urandom_range(99);
                        gap_hi = (reg_max_step == 0) ? 32'd1 :
                                 (reg_max_step > 200) ? 32'd200 : reg_max_step;
                        if (pct < 6)
                            gap = '0;
                        else if (pct < 12)
                            gap = reg_max_step + $urandom_range(1, 1000);
                        else if (pct < 16)
                            gap = $urandom;
                        else
                            gap = $urandom_range(1, gap_hi);
                        stamp_now += gap;
                        send_item(KIND_RATE, rate, stamp_now, '0);
                    end
                end
            end
        end
    endtask

    initial begin
        error_count     = 0;
        send_idle_pct   = 0;
        out_stall_pct   = 0;
        reg_target      = gyi_pkg::RST_TARGET;
        reg_max_step    = gyi_pkg::RST_MAX_STEP;
        reg_init_bias   = gyi_pkg::RST_INIT_BIAS;
        reg_bias_fixed  = gyi_pkg::RST_BIAS_FIXED;
        restart_state();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_kind          <= KIND_RATE;
        i_rate_value    <= '0;
        i_sample_time   <= '0;
        i_yaw_set_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_calibration();
        test_step_gaps();
        test_yaw_saturation();
        test_register_extremes();
        test_random_traffic();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/gyi_pkg.sv
rtl/gyi_div.sv
rtl/gyi_mac.sv
rtl/gyro_yaw_integrator.sv
sim/tb_gyro_yaw_integrator.sv
